// ----- rtl/countdown_action_timer_table_macros.svh -----
// ----------------------------------------------------------------------------
// countdown_action_timer_table_macros.svh
// Assertion macros used by the timer table RTL.
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_ACTION_TIMER_TABLE_MACROS_SVH
`define COUNTDOWN_ACTION_TIMER_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define CATT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer table assertion failed");

// Next-cycle implication, disabled during reset
`define CATT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer table assertion failed");

`else

`define CATT_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define CATT_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/catt_pkg.sv -----
// ----------------------------------------------------------------------------
// catt_pkg
// Shared types, codes and defaults of the countdown action timer table.
// ----------------------------------------------------------------------------
package catt_pkg;

   // Default sizing
   localparam int MAX_TIMERS_DEF  = 16;
   localparam int COUNT_WIDTH_DEF = 32;

   // Fixed field widths
   localparam int PERIOD_W = 32;
   localparam int TAG_W    = 8;
   localparam int EVENT_W  = 2;

   typedef logic [EVENT_W-1:0] event_type;
   typedef logic [TAG_W-1:0]   tag_type;

   // Request kinds
   localparam logic KIND_TICK     = 1'b0;
   localparam logic KIND_REGISTER = 1'b1;

   // Result event codes
   localparam event_type EV_FIRED      = 2'd0;
   localparam event_type EV_REGISTERED = 2'd1;
   localparam event_type EV_FULL       = 2'd2;

endpackage

// ----- rtl/catt_entry_ram.sv -----
// ----------------------------------------------------------------------------
// catt_entry_ram
// Timer entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module catt_entry_ram #(
   parameter int DEPTH  = catt_pkg::MAX_TIMERS_DEF,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 73
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);
   import catt_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/countdown_action_timer_table.sv -----
// ----------------------------------------------------------------------------
// countdown_action_timer_table
// Table of countdown timers kept in registration order, one-shot or periodic.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A register
// request answers in the next cycle with a single result (registered or table
// full) and the block is ready again at once. A tick walks the timers in use
// through the entry memory, one entry per cycle since the memory has one read
// port: busy stays high through the walk and, when any timer fires, through
// the flush state that follows it, and no transaction is taken meanwhile. Fire
// results come out in table order, at most one per cycle, each exactly one
// cycle on rsp_valid; the final one follows the walk with rsp_last set. The
// receiver cannot stall, so it must take every strobe. A tick with no timers
// in use, or where nothing fires, gives no result. A period of 0 counts as 1.
// ----------------------------------------------------------------------------
`include "countdown_action_timer_table_macros.svh"

module countdown_action_timer_table #(
   parameter int MAX_TIMERS  = catt_pkg::MAX_TIMERS_DEF,
   parameter int COUNT_WIDTH = catt_pkg::COUNT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [catt_pkg::PERIOD_W-1:0] req_period,
   input  logic                          req_periodic,
   input  catt_pkg::tag_type             req_tag,
   output logic                          rsp_valid,
   output catt_pkg::event_type           rsp_event_res,
   output catt_pkg::tag_type             rsp_fired_tag,
   output logic                          rsp_last
);
   import catt_pkg::*;

   localparam int IDX_W   = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
   localparam int CNT_W   = $clog2(MAX_TIMERS + 1);
   localparam int ENTRY_W = TAG_W + 2 * COUNT_WIDTH + 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] wr_ff, wr_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic             pend_valid_ff, pend_valid_in;
   tag_type          pend_tag_ff, pend_tag_in;
   logic             rsp_valid_ff, rsp_valid_in;
   event_type        rsp_event_ff, rsp_event_in;
   tag_type          rsp_tag_ff, rsp_tag_in;
   logic             rsp_last_ff, rsp_last_in;

   logic               accept;
   logic [COUNT_WIDTH-1:0] period_cw, period_fix;
   logic               mem_wr_en;
   logic [IDX_W-1:0]   mem_wr_addr, mem_rd_addr;
   logic [ENTRY_W-1:0] mem_wr_data, mem_rd_data;

   tag_type                ent_tag;
   logic [COUNT_WIDTH-1:0] ent_count, ent_reload, new_count;
   logic                   ent_rep, fire, keep, walk_end;

   catt_entry_ram #(
      .DEPTH  (MAX_TIMERS),
      .ADDR_W (IDX_W),
      .DATA_W (ENTRY_W)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;

   // period fitted to the counter width, zero promoted to one
   assign period_cw  = COUNT_WIDTH'(req_period);
   assign period_fix = (period_cw == '0) ? COUNT_WIDTH'(1) : period_cw;

   // entry unpack: {tag, count, reload, repeats}
   assign ent_tag    = mem_rd_data[ENTRY_W-1 -: TAG_W];
   assign ent_count  = mem_rd_data[2*COUNT_WIDTH -: COUNT_WIDTH];
   assign ent_reload = mem_rd_data[COUNT_WIDTH -: COUNT_WIDTH];
   assign ent_rep    = mem_rd_data[0];

   // per-entry tick update
   assign fire      = (ent_count == COUNT_WIDTH'(1));
   assign keep      = ~fire | ent_rep;
   assign new_count = fire ? ent_reload : (ent_count - COUNT_WIDTH'(1));
   assign walk_end  = ((rd_ff + CNT_W'(1)) == used_ff);

   // control and memory access
   always_comb begin
      state_in      = state_ff;
      rd_in         = rd_ff;
      wr_in         = wr_ff;
      used_in       = used_ff;
      pend_valid_in = pend_valid_ff;
      pend_tag_in   = pend_tag_ff;
      rsp_valid_in  = 1'b0;
      rsp_event_in  = EV_FIRED;
      rsp_tag_in    = pend_tag_ff;
      rsp_last_in   = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = used_ff[IDX_W-1:0];
      mem_wr_data   = {req_tag, period_fix, period_fix, req_periodic};
      mem_rd_addr   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_REGISTER) begin
                  rsp_valid_in = 1'b1;
                  rsp_tag_in   = req_tag;
                  rsp_last_in  = 1'b1;
                  if (used_ff == CNT_W'(MAX_TIMERS)) begin
                     rsp_event_in = EV_FULL;
                  end else begin
                     rsp_event_in = EV_REGISTERED;
                     mem_wr_en    = 1'b1;
                     used_in      = used_ff + CNT_W'(1);
                  end
               end else if (used_ff != '0) begin
                  // entry 0 is being read this cycle
                  rd_in    = '0;
                  wr_in    = '0;
                  state_in = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            // prefetch next entry; writes only hit indexes already read
            mem_rd_addr = IDX_W'(rd_ff + CNT_W'(1));
            mem_wr_addr = wr_ff[IDX_W-1:0];
            mem_wr_data = {ent_tag, new_count, ent_reload, ent_rep};
            if (keep) begin
               mem_wr_en = 1'b1;
               wr_in     = wr_ff + CNT_W'(1);
            end
            // hold one fire back so the final one can carry last
            if (fire) begin
               pend_valid_in = 1'b1;
               pend_tag_in   = ent_tag;
               rsp_valid_in  = pend_valid_ff;
            end
            if (walk_end) begin
               used_in  = keep ? (wr_ff + CNT_W'(1)) : wr_ff;
               state_in = (fire | pend_valid_ff) ? ST_FLUSH : ST_IDLE;
            end else begin
               rd_in = rd_ff + CNT_W'(1);
            end
         end

         ST_FLUSH: begin
            rsp_valid_in  = 1'b1;
            rsp_last_in   = 1'b1;
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_ff        <= rd_in;
      wr_ff        <= wr_in;
      pend_tag_ff  <= pend_tag_in;
      rsp_event_ff <= rsp_event_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_event_ff;
   assign rsp_fired_tag = rsp_tag_ff;
   assign rsp_last      = rsp_last_ff;

   // checks
   `CATT_ASSERT_IMPL(a_used_bound, clock, reset, 1'b1, used_ff <= CNT_W'(MAX_TIMERS))
   `CATT_ASSERT_IMPL(a_idle_no_pend, clock, reset, state_ff == ST_IDLE, !pend_valid_ff)
   `CATT_ASSERT_IMPL(a_compact_order, clock, reset, state_ff == ST_WALK,
                     (wr_ff <= rd_ff) && (rd_ff < used_ff))
   `CATT_ASSERT_NEXT(a_reg_answer, clock, reset, accept && (req_kind == KIND_REGISTER),
                     rsp_valid_ff && rsp_last_ff)
   `CATT_ASSERT_NEXT(a_flush_last, clock, reset, state_ff == ST_FLUSH,
                     rsp_valid_ff && rsp_last_ff && (state_ff == ST_IDLE))

endmodule
